>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sma_pkg.sv
package sma_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int PERIOD_W     = 9;
    localparam int PERIOD_MAX   = 511;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd20;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } sample_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       valid_res;
    } result_t;

endpackage

>>> rtl/sma_stream_if.sv
interface sma_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

>>> rtl/simple_moving_average.sv
// Moving average of the newest period samples, signed Q16.16, one result per request.
// Once the window is full a request goes through accept, ring update, divider load,
// one quotient bit a cycle from the restoring divider, and emit.
// While the window fills a request skips divider load and divide; the result sits in an output register.
// Reset is asynchronous, active low: period 20, sum, slot and fill count cleared;
// the ring store is not cleared, only entries written since the last clear are read.
`include "assert_macros.svh"

module simple_moving_average #(
    parameter int WINDOW = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          period_we,
    input  logic [sma_pkg::PERIOD_W-1:0]  period_wdata,
    sma_stream_if.sink                    samples,
    sma_stream_if.source                  results
);

    import sma_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int P_LIM  = (WINDOW < PERIOD_MAX) ? WINDOW : PERIOD_MAX;
    localparam int SUM_W  = SAMPLE_W + $clog2(P_LIM);
    localparam int CMP_W  = (SLOT_W + 1 > PERIOD_W) ? SLOT_W + 1 : PERIOD_W;
    localparam int AW     = CMP_W + 1;
    localparam int ITER_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic signed [SUM_W-1:0]    window_sum_reg;
    logic [SLOT_W-1:0]          write_slot_reg;
    logic [PERIOD_W-1:0]        filled_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [SUM_W-1:0]           quo_reg;
    logic [PERIOD_W-1:0]        rem_reg;
    logic                       neg_reg;
    logic                       res_valid_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic                       out_valid_reg;
    result_t                    out_data_reg;

    logic [PERIOD_W-1:0]        p_eff;
    logic [AW-1:0]              old_pos;
    logic [SLOT_W-1:0]          oldest;
    logic                       accept;
    logic                       full;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]           sum_mag;
    logic [PERIOD_W:0]          rem_sh;
    logic                       rem_ge;
    logic [PERIOD_W-1:0]        rem_next;
    logic [SAMPLE_W-1:0]        avg_mag;
    logic                       out_free;

    // Clamp period to one at the bottom and to the ring depth at the top.
    always_comb
    begin
        priority if (period_reg == '0)
        begin
            p_eff = PERIOD_W'(1);
        end
        else if (CMP_W'(period_reg) > CMP_W'(WINDOW))
        begin
            p_eff = PERIOD_W'(P_LIM);
        end
        else
        begin
            p_eff = period_reg;
        end
    end

    // Slot of the sample that leaves the window.
    always_comb
    begin
        old_pos = AW'(write_slot_reg) + AW'(WINDOW) - AW'(p_eff);
        if (old_pos >= AW'(WINDOW))
        begin
            oldest = SLOT_W'(old_pos - AW'(WINDOW));
        end
        else
        begin
            oldest = SLOT_W'(old_pos);
        end
    end

    assign accept        = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);
    assign full          = (filled_reg >= p_eff);

    sma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_history (
        .clk   (clk),
        .we    (state_reg == ST_UPDATE),
        .waddr (write_slot_reg),
        .wdata (sample_reg),
        .re    (accept),
        .raddr (oldest),
        .rdata (old_sample)
    );

    always_comb
    begin
        sum_next = window_sum_reg + {{(SUM_W - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        if (full)
        begin
            sum_next = sum_next - {{(SUM_W - SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
        end
    end

    assign sum_mag  = window_sum_reg[SUM_W-1] ? SUM_W'(-window_sum_reg) : SUM_W'(window_sum_reg);
    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, p_eff});
    assign rem_next = rem_ge ? PERIOD_W'(rem_sh - {1'b0, p_eff}) : PERIOD_W'(rem_sh);
    assign avg_mag  = quo_reg[SAMPLE_W-1:0];
    assign out_free = !out_valid_reg || results.ready;

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            period_reg     <= PERIOD_RESET;
            window_sum_reg <= '0;
            write_slot_reg <= '0;
            filled_reg     <= '0;
            sample_reg     <= '0;
            quo_reg        <= '0;
            rem_reg        <= '0;
            neg_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
            iter_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= samples.data.sample;
                        state_reg  <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    window_sum_reg <= sum_next;
                    write_slot_reg <= (write_slot_reg == SLOT_W'(WINDOW - 1)) ?
                                      '0 : write_slot_reg + 1'b1;
                    if (!full)
                    begin
                        filled_reg <= filled_reg + 1'b1;
                    end
                    if (full || (filled_reg + 1'b1 >= p_eff))
                    begin
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        quo_reg       <= '0;
                        neg_reg       <= 1'b0;
                        res_valid_reg <= 1'b0;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_LOAD:
                begin
                    quo_reg       <= sum_mag;
                    neg_reg       <= window_sum_reg[SUM_W-1];
                    rem_reg       <= '0;
                    iter_reg      <= '0;
                    res_valid_reg <= 1'b1;
                    state_reg     <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    quo_reg  <= {quo_reg[SUM_W-2:0], rem_ge};
                    rem_reg  <= rem_next;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // Hold until the output register is free.
                    if (out_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.average   <= neg_reg ? -avg_mag : avg_mag;
                        out_data_reg.valid_res <= res_valid_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // A period write drops the stored history.
            if (period_we)
            begin
                period_reg     <= period_wdata;
                window_sum_reg <= '0;
                write_slot_reg <= '0;
                filled_reg     <= '0;
            end
        end
    end

    `ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, filled_reg <= p_eff, "fill count above period")
    `ASSERT_IMPLIES(a_div_count, clk, rst_n, state_reg == ST_DIVIDE, iter_reg < ITER_W'(SUM_W), "divider overran")
    `ASSERT_IMPLIES(a_zero_unfilled, clk, rst_n, out_valid_reg && !out_data_reg.valid_res, out_data_reg.average == '0, "non-zero average before window full")
    `ASSERT_NEXT(a_fill_result, clk, rst_n, state_reg == ST_UPDATE && !full && filled_reg + 1'b1 < p_eff, state_reg == ST_EMIT && !res_valid_reg, "filling request did not bypass divider")

endmodule

>>> rtl/sma_ram.sv
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/tb_simple_moving_average.sv
`timescale 1ns / 100ps

module tb_simple_moving_average;
    import sma_pkg::*;

    localparam int WINDOW       = 256;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_TICKS = 8;
    localparam int DRAIN_TICKS  = 60;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [SAMPLE_W-1:0] MAX_SAMPLE = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] MIN_SAMPLE = 32'sh8000_0000;

    typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idling_t;
    typedef enum int {MIX_WIDE, MIX_EXTREME, MIX_NEAR_ZERO} sample_mix_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                period_we;
    logic [PERIOD_W-1:0] period_wdata;

    sma_stream_if #(.payload_t(sample_req_t)) sample_ch ();
    sma_stream_if #(.payload_t(result_t))     result_ch ();

    simple_moving_average #(
        .WINDOW(WINDOW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_we    (period_we),
        .period_wdata (period_wdata),
        .samples      (sample_ch),
        .results      (result_ch)
    );

    // Own copy of the averaging state
    logic signed [SAMPLE_W-1:0] sample_ring [WINDOW];
    logic signed [63:0]         ring_total;
    int unsigned                ring_slot;
    int unsigned                fill_count;
    logic [PERIOD_W-1:0]        period_reg;
    result_t                    pending_averages [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    always #5 clk = ~clk;

    function automatic int unsigned span_len();
        int unsigned p;
        p = period_reg;
        if (p == 0)
            p = 1;
        if (p > WINDOW)
            p = WINDOW;
        return p;
    endfunction

    function automatic void predict_average(input logic signed [SAMPLE_W-1:0] s);
        int unsigned        p;
        int unsigned        oldest;
        logic signed [63:0] quot;
        result_t            r;
        p = span_len();
        if (fill_count >= p)
        begin
            oldest = (ring_slot + WINDOW - p) % WINDOW;
            ring_total = ring_total - sample_ring[oldest];
        end
        else
            fill_count++;
        ring_total = ring_total + s;
        sample_ring[ring_slot] = s;
        ring_slot = (ring_slot + 1) % WINDOW;
        if (fill_count >= p)
        begin
            // signed divide truncates toward zero
            quot = ring_total / longint'(p);
            r.average = quot[SAMPLE_W-1:0];
            r.valid_res = 1'b1;
        end
        else
            r = '0;
        pending_averages.push_back(r);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input sample_mix_t mix);
        int pick;
        pick = $urandom_range(99);
        case (mix)
            MIX_EXTREME:
                if (pick < 45)
                    return MAX_SAMPLE;
                else if (pick < 90)
                    return MIN_SAMPLE;
                else
                    return $urandom;
            MIX_NEAR_ZERO:
                return $urandom_range(512) - 256;
            default:
                if (pick < 5)
                    return MAX_SAMPLE;
                else if (pick < 10)
                    return MIN_SAMPLE;
                else
                    return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        if (mismatches < MAX_REPORTS)
            $display("mismatch (%s): expected average %0d valid %0b, got average %0d valid %0b",
                     what, want.average, want.valid_res, got.average, got.valid_res);
        mismatches++;
    endtask

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SOURCE: begin src_idle_pct = 45; sink_stall_pct = 0;  end
            IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 45; end
            default:     begin src_idle_pct = 32; sink_stall_pct = 32; end
        endcase
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data.sample <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predict_average(s);
    endtask

    task automatic wait_results();
        sample_ch.valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        wait_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        period_we <= 1'b1;
        period_wdata <= value;
        @(posedge clk);
        period_we <= 1'b0;
        period_reg = value;
        ring_total = '0;
        ring_slot = 0;
        fill_count = 0;
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] value, input idling_t mode,
                             input sample_mix_t mix, input int extra);
        int count;
        write_period(value);
        set_idling(mode);
        count = span_len() + extra;
        repeat (count) send_sample(rand_sample(mix));
    endtask

    // Period left at its reset value: fill, then slide
    task automatic test_reset_period();
        set_idling(IDLE_NONE);
        repeat (40) send_sample(rand_sample(MIX_WIDE));
    endtask

    task automatic test_directed_edges();
        set_idling(IDLE_NONE);
        write_period(1);
        send_sample(MAX_SAMPLE);
        send_sample(MIN_SAMPLE);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        // zero period behaves as one
        write_period(0);
        send_sample(MIN_SAMPLE);
        send_sample(MAX_SAMPLE);
        // window of two: full-scale sums and truncation of negative halves
        write_period(2);
        send_sample(MAX_SAMPLE);
        send_sample(MAX_SAMPLE);
        send_sample(MIN_SAMPLE);
        send_sample(MIN_SAMPLE);
        send_sample(-3);
        send_sample(0);
        send_sample(3);
        write_period(3);
        send_sample(5);
        send_sample(-7);
        send_sample(1);
    endtask

    task automatic test_random_periods();
        logic [PERIOD_W-1:0] plan_period [12] = '{5, 256, 1, 17, 0, 40, 511, 3, 9, 64, 2, 28};
        sample_mix_t         plan_mix    [12] = '{MIX_WIDE, MIX_EXTREME, MIX_WIDE,
                                                 MIX_NEAR_ZERO, MIX_WIDE, MIX_EXTREME,
                                                 MIX_WIDE, MIX_NEAR_ZERO, MIX_EXTREME,
                                                 MIX_WIDE, MIX_EXTREME, MIX_WIDE};
        for (int i = 0; i < 12; i++)
            run_phase(plan_period[i], idling_t'(i % 4), plan_mix[i], $urandom_range(10, 40));
        for (int i = 0; i < 8; i++)
            run_phase(PERIOD_W'($urandom_range(1, 24)), idling_t'(i % 4),
                      sample_mix_t'($urandom_range(0, 2)), $urandom_range(20, 40));
    endtask

    // Hold each request until the previous average has come back
    task automatic test_paced_sender();
        write_period(4);
        set_idling(IDLE_SINK);
        repeat (30)
        begin
            send_sample(rand_sample(MIX_WIDE));
            wait_results();
        end
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (pending_averages.size() == 0)
                report_mismatch("unexpected result", '0, got);
            else
            begin
                want = pending_averages.pop_front();
                if (got.average !== want.average)
                    report_mismatch("average", want, got);
                if (got.valid_res !== want.valid_res)
                    report_mismatch("valid_res", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        period_we = 1'b0;
        period_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        result_ch.ready = 1'b0;
        period_reg = PERIOD_RESET;
        ring_total = '0;
        ring_slot = 0;
        fill_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_period();
        test_directed_edges();
        test_random_periods();
        test_paced_sender();

        wait_results();
        repeat (DRAIN_TICKS) @(posedge clk);
        if (mismatches == 0 && pending_averages.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sma_pkg.sv
rtl/sma_stream_if.sv
rtl/sma_ram.sv
rtl/simple_moving_average.sv
tb/tb_simple_moving_average.sv
